/* rtl/wrc_pkg.sv */
// Shared types, codes and constants of the WAV RIFF chunk parser.
package wrc_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 112;
  localparam int unsigned OUT_USER_W  = 3;

  // Width of the frame size: (bits / 8) times channels.
  localparam int unsigned BPS_W       = 13;
  localparam int unsigned FRAME_W     = BPS_W + 16;
  localparam int unsigned LEN_W       = 32;

  // Four-character tags as read little-endian from the stream.
  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;

  // Format codes and limits.
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] FMT_FLOAT   = 16'd3;
  localparam logic [15:0] BITS_PCM    = 16'd16;
  localparam logic [15:0] BITS_FLOAT  = 16'd32;
  localparam logic [15:0] BITS_MIN    = 16'd8;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  // Verdict codes.
  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_OK        = 4'd1;
  localparam logic [3:0] ST_BAD_RIFF  = 4'd2;
  localparam logic [3:0] ST_BAD_WAVE  = 4'd3;
  localparam logic [3:0] ST_TRUNC     = 4'd4;
  localparam logic [3:0] ST_SHORT_FMT = 4'd5;
  localparam logic [3:0] ST_MISSING   = 4'd6;
  localparam logic [3:0] ST_ZERO      = 4'd7;
  localparam logic [3:0] ST_PARTIAL   = 4'd8;
  localparam logic [3:0] ST_UNSUP     = 4'd9;

  // Parse phase of the byte walker.
  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID,
    PH_SIZE,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE,
    PH_ERR
  } phase_e;

  // Kind of the chunk being walked.
  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_FMT,
    KIND_DATA
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   take;
    logic   finish;
    logic   clear;
    phase_e phase;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        word_done;
    logic [31:0] word;
    logic        pad_pending;
    logic        fmt_last;
    logic        left_one;
    kind_e       kind;
    logic        fmt_seen;
    logic        data_seen;
  } sts_t;

  // Captured fmt fields and data length.
  typedef struct packed {
    logic [15:0] format_code;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] length;
  } held_t;

endpackage

/* rtl/wrc_mod.sv */
// Frame size multiply and bit-serial remainder of the data length by the frame size.
module wrc_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wrc_pkg::LEN_W-1:0] dividend_i,
  input  logic [15:0]               bits_i,
  input  logic [15:0]               chans_i,
  output logic                      done_o,
  output logic                      rem_zero_o
);
  import wrc_pkg::*;

  localparam int unsigned STEPS = LEN_W;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [FRAME_W-1:0] div_q, div_d;
  logic [FRAME_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [FRAME_W:0]   trial;
  logic [FRAME_W:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, quo_q[LEN_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      div_d  = FRAME_W'(bits_i[15:3]) * FRAME_W'(chans_i);
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[FRAME_W-1:0];
      end else begin
        rem_d = trial[FRAME_W-1:0];
      end
      quo_d = {quo_q[LEN_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

/* rtl/wrc_dp.sv */
// Datapath of the parser: field assembly, byte counters and captured fmt fields.
module wrc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrc_pkg::cmd_t                 cmd_i,
  input  logic [wrc_pkg::IN_DATA_W-1:0] file_byte_i,
  output wrc_pkg::sts_t                 sts_o,
  output wrc_pkg::held_t                held_o,
  output logic                          pcm_valid_o,
  output logic [7:0]                    pcm_byte_o,
  output logic                          pcm_restart_o
);
  import wrc_pkg::*;

  logic [31:0] shift_q;
  logic [31:0] left_q;
  logic        pad_q;
  logic [3:0]  idx_q;
  kind_e       kind_q;
  logic [15:0] fmt_code_q;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [15:0] bits_q;
  logic [31:0] len_q;
  logic        fmt_seen_q;
  logic        data_seen_q;
  logic [31:0] word;
  logic        word_done;

  // The field as it stands once this byte is shifted in.
  assign word      = {file_byte_i, shift_q[31:8]};
  assign word_done = (idx_q == 4'd3);

  assign sts_o.word_done   = word_done;
  assign sts_o.word        = word;
  assign sts_o.pad_pending = pad_q;
  assign sts_o.fmt_last    = (idx_q == 4'd15);
  assign sts_o.left_one    = (left_q == 32'd1);
  assign sts_o.kind        = kind_q;
  assign sts_o.fmt_seen    = fmt_seen_q;
  assign sts_o.data_seen   = data_seen_q;

  assign held_o.format_code = fmt_code_q;
  assign held_o.channels    = chan_q;
  assign held_o.rate        = rate_q;
  assign held_o.bits        = bits_q;
  assign held_o.length      = len_q;

  // Payload bytes of a data chunk pass straight through.
  assign pcm_valid_o   = (cmd_i.phase == PH_DATA);
  assign pcm_byte_o    = pcm_valid_o ? file_byte_i : 8'd0;
  assign pcm_restart_o = pcm_valid_o && (left_q == len_q);

  // Per-byte update of the walker registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      left_q      <= '0;
      pad_q       <= 1'b0;
      idx_q       <= '0;
      kind_q      <= KIND_OTHER;
      fmt_code_q  <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      len_q       <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
    end else if (cmd_i.clear) begin
      shift_q     <= '0;
      left_q      <= '0;
      pad_q       <= 1'b0;
      idx_q       <= '0;
      kind_q      <= KIND_OTHER;
      fmt_code_q  <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      len_q       <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
    end else if (cmd_i.take) begin
      case (cmd_i.phase)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_SIZE: begin
          shift_q <= word;
          idx_q   <= word_done ? 4'd0 : idx_q + 4'd1;
          if (cmd_i.phase == PH_SIZE && word_done) begin
            pad_q  <= word[0];
            left_q <= word;
            if (kind_q == KIND_DATA) begin
              len_q <= word;
            end
          end
        end
        PH_ID: begin
          if (pad_q) begin
            // The pad byte after an odd-size chunk is dropped whatever it holds.
            pad_q <= 1'b0;
          end else begin
            shift_q <= word;
            idx_q   <= word_done ? 4'd0 : idx_q + 4'd1;
            if (word_done) begin
              if (word == TAG_FMT) begin
                kind_q <= KIND_FMT;
              end else if (word == TAG_DATA) begin
                kind_q <= KIND_DATA;
              end else begin
                kind_q <= KIND_OTHER;
              end
            end
          end
        end
        PH_FMT: begin
          case (idx_q)
            4'd0:    fmt_code_q[7:0]  <= file_byte_i;
            4'd1:    fmt_code_q[15:8] <= file_byte_i;
            4'd2:    chan_q[7:0]      <= file_byte_i;
            4'd3:    chan_q[15:8]     <= file_byte_i;
            4'd4:    rate_q[7:0]      <= file_byte_i;
            4'd5:    rate_q[15:8]     <= file_byte_i;
            4'd6:    rate_q[23:16]    <= file_byte_i;
            4'd7:    rate_q[31:24]    <= file_byte_i;
            4'd14:   bits_q[7:0]      <= file_byte_i;
            4'd15:   bits_q[15:8]     <= file_byte_i;
            default: ;
          endcase
          left_q <= left_q - 32'd1;
          idx_q  <= idx_q + 4'd1;
        end
        PH_SKIP, PH_DATA: begin
          left_q <= left_q - 32'd1;
        end
        default: ;
      endcase
      // A chunk that ends marks its kind as seen.
      if (cmd_i.finish) begin
        if (kind_q == KIND_FMT) begin
          fmt_seen_q <= 1'b1;
        end
        if (kind_q == KIND_DATA) begin
          data_seen_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/wrc_ctrl.sv */
// Controller of the parser: parse phase, input handshake and final verdict sequence.
module wrc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output wrc_pkg::cmd_t  cmd_o,
  input  wrc_pkg::sts_t  sts_i,
  input  wrc_pkg::held_t held_i,
  output logic           mod_start_o,
  input  logic           mod_done_i,
  input  logic           mod_rem_zero_i,
  output logic           verdict_load_o,
  output logic [3:0]     status_o
);
  import wrc_pkg::*;

  typedef enum logic [1:0] {
    M_RUN,
    M_VERDICT,
    M_MOD
  } mode_e;

  mode_e      mode_q, mode_d;
  phase_e     phase_q, phase_d;
  logic [3:0] err_q, err_d;
  logic       take;
  logic       finish;
  logic       both;
  phase_e     fin_phase;
  logic       fields_zero;
  logic       fmt_ok;

  assign in_ready_o = (mode_q == M_RUN) && out_free_i;
  assign take       = in_valid_i && in_ready_o;

  // Walking stops once a whole fmt chunk and a whole data chunk are behind us.
  assign both = (sts_i.fmt_seen || sts_i.kind == KIND_FMT) &&
                (sts_i.data_seen || sts_i.kind == KIND_DATA);
  assign fin_phase = both ? PH_DONE : PH_ID;

  assign fields_zero = (held_i.channels == '0) || (held_i.rate == '0) ||
                       (held_i.bits < BITS_MIN);
  assign fmt_ok = ((held_i.format_code == FMT_FLOAT) && (held_i.bits == BITS_FLOAT)) ||
                  ((held_i.format_code == FMT_PCM) && (held_i.bits == BITS_PCM));

  // Next parse phase for an accepted byte, and the verdict sequence.
  always_comb begin
    phase_d        = phase_q;
    err_d          = err_q;
    mode_d         = mode_q;
    finish         = 1'b0;
    mod_start_o    = 1'b0;
    verdict_load_o = 1'b0;
    status_o       = ST_NONE;
    case (mode_q)
      M_RUN: begin
        if (take) begin
          case (phase_q)
            PH_RIFF: begin
              if (sts_i.word_done) begin
                if (sts_i.word == TAG_RIFF) begin
                  phase_d = PH_RSIZE;
                end else begin
                  phase_d = PH_ERR;
                  err_d   = ST_BAD_RIFF;
                end
              end
            end
            PH_RSIZE: begin
              if (sts_i.word_done) begin
                phase_d = PH_WAVE;
              end
            end
            PH_WAVE: begin
              if (sts_i.word_done) begin
                if (sts_i.word == TAG_WAVE) begin
                  phase_d = PH_ID;
                end else begin
                  phase_d = PH_ERR;
                  err_d   = ST_BAD_WAVE;
                end
              end
            end
            PH_ID: begin
              if (!sts_i.pad_pending && sts_i.word_done) begin
                phase_d = PH_SIZE;
              end
            end
            PH_SIZE: begin
              if (sts_i.word_done) begin
                case (sts_i.kind)
                  KIND_FMT: begin
                    if (sts_i.word < FMT_MIN_LEN) begin
                      phase_d = PH_ERR;
                      err_d   = ST_SHORT_FMT;
                    end else begin
                      phase_d = PH_FMT;
                    end
                  end
                  KIND_DATA: begin
                    if (sts_i.word == '0) begin
                      finish  = 1'b1;
                      phase_d = fin_phase;
                    end else begin
                      phase_d = PH_DATA;
                    end
                  end
                  default: begin
                    if (sts_i.word == '0) begin
                      finish  = 1'b1;
                      phase_d = fin_phase;
                    end else begin
                      phase_d = PH_SKIP;
                    end
                  end
                endcase
              end
            end
            PH_FMT: begin
              if (sts_i.fmt_last) begin
                if (sts_i.left_one) begin
                  finish  = 1'b1;
                  phase_d = fin_phase;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end
            PH_SKIP, PH_DATA: begin
              if (sts_i.left_one) begin
                finish  = 1'b1;
                phase_d = fin_phase;
              end
            end
            default: ;
          endcase
          if (in_last_i) begin
            mode_d = M_VERDICT;
          end
        end
      end
      M_VERDICT: begin
        verdict_load_o = 1'b1;
        case (phase_q)
          PH_ERR:  status_o = err_q;
          PH_ID:   status_o = ST_MISSING;
          PH_DONE: begin
            if (fields_zero) begin
              status_o = ST_ZERO;
            end else begin
              // Whole-frame check needs the remainder unit.
              verdict_load_o = 1'b0;
              mod_start_o    = 1'b1;
              mode_d         = M_MOD;
            end
          end
          default: status_o = ST_TRUNC;
        endcase
      end
      M_MOD: begin
        if (mod_done_i) begin
          verdict_load_o = 1'b1;
          if (!mod_rem_zero_i) begin
            status_o = ST_PARTIAL;
          end else if (fmt_ok) begin
            status_o = ST_OK;
          end else begin
            status_o = ST_UNSUP;
          end
        end
      end
      default: mode_d = M_RUN;
    endcase
    // Once the verdict goes out the parser starts over.
    if (verdict_load_o) begin
      phase_d = PH_RIFF;
      err_d   = ST_NONE;
      mode_d  = M_RUN;
    end
  end

  assign cmd_o.take   = take;
  assign cmd_o.finish = finish;
  assign cmd_o.clear  = verdict_load_o;
  assign cmd_o.phase  = phase_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_RUN;
      phase_q <= PH_RIFF;
      err_q   <= ST_NONE;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      err_q   <= err_d;
    end
  end

endmodule

/* rtl/wav_riff_chunk_parser_core.sv */
// Top level of the WAV RIFF chunk parser with its output register.
//
// The input channel takes a WAV file one byte per item: tdata holds the byte
// and tlast marks the final byte of the file. Every accepted byte gives one
// output item. For an ordinary byte the item carries the data-chunk payload
// byte when there is one (tuser bit 0 set, bit 1 set on the first byte of a
// data chunk) and a zero status. For the byte marked tlast the item also
// carries the verdict, the float flag, the captured fmt fields and the length
// of the last data chunk; the parser then starts over on a new file.
// Ordinary bytes are taken one per cycle while the output register is free;
// each item shows in the cycle after its byte. The final byte leads to its
// verdict, via the whole-frame check when it runs, a bit-serial remainder at
// one bit per cycle over the 32-bit data length. No byte is taken meanwhile.
// A single output register parts the two sides: while it holds an item the
// receiver has not taken, the input is stalled. Reset empties the output
// register and returns the parser to the RIFF tag.
module wav_riff_chunk_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: file_byte[7:0]
  input  logic [wrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tlast: end_of_file
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: pcm_byte[7:0], status[11:8], channel_count[27:12], rate_hz[59:28],
  //        sample_bits[75:60], payload_length[107:76], zeros[111:108]
  output logic [wrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: pcm_valid[0], pcm_restart[1], is_float[2]
  output logic [wrc_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import wrc_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  held_t       held;
  logic        out_free;
  logic        mod_start;
  logic        mod_done;
  logic        mod_rem_zero;
  logic        verdict_load;
  logic [3:0]  verdict;
  logic        dp_pcm_valid;
  logic [7:0]  dp_pcm_byte;
  logic        dp_pcm_restart;

  logic        out_valid_q, out_valid_d;
  logic        pcm_valid_q;
  logic [7:0]  pcm_byte_q;
  logic        pcm_restart_q;
  logic [3:0]  status_q;
  logic        is_float_q;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [15:0] bits_q;
  logic [31:0] len_q;

  assign out_free = !out_valid_q || m_axis_tready;

  wrc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_last_i      (s_axis_tlast),
    .out_free_i     (out_free),
    .in_ready_o     (s_axis_tready),
    .cmd_o          (cmd),
    .sts_i          (sts),
    .held_i         (held),
    .mod_start_o    (mod_start),
    .mod_done_i     (mod_done),
    .mod_rem_zero_i (mod_rem_zero),
    .verdict_load_o (verdict_load),
    .status_o       (verdict)
  );

  wrc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .file_byte_i   (s_axis_tdata),
    .sts_o         (sts),
    .held_o        (held),
    .pcm_valid_o   (dp_pcm_valid),
    .pcm_byte_o    (dp_pcm_byte),
    .pcm_restart_o (dp_pcm_restart)
  );

  wrc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (held.length),
    .bits_i     (held.bits),
    .chans_i    (held.channels),
    .done_o     (mod_done),
    .rem_zero_o (mod_rem_zero)
  );

  // An ordinary byte fills the register at once; the final byte waits for its verdict.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.take && !s_axis_tlast) begin
      out_valid_d = 1'b1;
    end else if (verdict_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd.take) begin
      pcm_valid_q   <= dp_pcm_valid;
      pcm_byte_q    <= dp_pcm_byte;
      pcm_restart_q <= dp_pcm_restart;
      status_q      <= ST_NONE;
      is_float_q    <= 1'b0;
      chan_q        <= '0;
      rate_q        <= '0;
      bits_q        <= '0;
      len_q         <= '0;
    end else if (verdict_load) begin
      status_q   <= verdict;
      is_float_q <= (verdict == ST_OK) && (held.format_code == FMT_FLOAT);
      chan_q     <= held.channels;
      rate_q     <= held.rate;
      bits_q     <= held.bits;
      len_q      <= held.length;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, len_q, bits_q, rate_q, chan_q, status_q, pcm_byte_q};
  assign m_axis_tuser  = {is_float_q, pcm_restart_q, pcm_valid_q};

endmodule

/* dv/wav_riff_chunk_parser_checker.sv */
// Checker for the WAV RIFF chunk parser: predicts each output item and compares it.
`timescale 1ns / 100ps

module wav_riff_chunk_parser_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // tdata: file_byte[7:0]
  input  logic [wrc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tlast: end_of_file
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: pcm_byte[7:0], status[11:8], channel_count[27:12], rate_hz[59:28],
  //        sample_bits[75:60], payload_length[107:76], zeros[111:108]
  input  logic [wrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: pcm_valid[0], pcm_restart[1], is_float[2]
  input  logic [wrc_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_count_o
);
  import wrc_pkg::*;

  // One output item of the parser, unpacked.
  typedef struct packed {
    logic        pcm_valid;
    logic [7:0]  pcm_byte;
    logic        pcm_restart;
    logic [3:0]  status;
    logic        is_float;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] length;
  } wav_item_t;

  // Shadow of the parser state.
  phase_e      walk_phase;
  kind_e       chunk_type;
  logic [31:0] tag_shift;
  logic [31:0] remaining;
  logic        pad_owed;
  logic [15:0] fmt_code_h;
  logic [15:0] chan_h;
  logic [31:0] rate_h;
  logic [15:0] bits_h;
  logic [31:0] data_len_h;
  logic        fmt_done;
  logic        data_done;
  logic [3:0]  early_status;
  logic [4:0]  field_pos;

  wav_item_t   parsed_item_q[$];
  int unsigned mismatch_total = 0;
  int unsigned pending_r = 0;

  assign fail_count_o    = mismatch_total;
  assign pending_count_o = pending_r;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_total++;
  endtask

  function automatic void clear_parse();
    walk_phase   = PH_RIFF;
    chunk_type   = KIND_OTHER;
    tag_shift    = '0;
    remaining    = '0;
    pad_owed     = 1'b0;
    fmt_code_h   = '0;
    chan_h       = '0;
    rate_h       = '0;
    bits_h       = '0;
    data_len_h   = '0;
    fmt_done     = 1'b0;
    data_done    = 1'b0;
    early_status = ST_NONE;
    field_pos    = '0;
  endfunction

  function automatic void abort_parse(input logic [3:0] code);
    early_status = code;
    walk_phase   = PH_ERR;
  endfunction

  // A chunk is complete: parsing stops once both fmt and data are in.
  function automatic void finish_chunk();
    if (chunk_type == KIND_FMT) fmt_done = 1'b1;
    if (chunk_type == KIND_DATA) data_done = 1'b1;
    field_pos  = '0;
    walk_phase = (fmt_done && data_done) ? PH_DONE : PH_ID;
  endfunction

  // The chunk size decides where the body goes.
  function automatic void take_size(input logic [31:0] size);
    pad_owed  = size[0];
    remaining = size;
    field_pos = '0;
    case (chunk_type)
      KIND_FMT: begin
        if (size < FMT_MIN_LEN) abort_parse(ST_SHORT_FMT);
        else walk_phase = PH_FMT;
      end
      KIND_DATA: begin
        data_len_h = size;
        if (size == 0) finish_chunk();
        else walk_phase = PH_DATA;
      end
      default: begin
        if (size == 0) finish_chunk();
        else walk_phase = PH_SKIP;
      end
    endcase
  endfunction

  // Final checks on the captured format, in priority order.
  function automatic logic [3:0] file_verdict();
    logic [31:0] bytes_per_sample;
    logic [31:0] frame_bytes;
    case (walk_phase)
      PH_ERR:  return early_status;
      PH_ID:   return ST_MISSING;
      PH_DONE: ;
      default: return ST_TRUNC;
    endcase
    if (chan_h == 0 || rate_h == 0 || bits_h == 0) return ST_ZERO;
    bytes_per_sample = 32'(bits_h) / 8;
    if (bytes_per_sample == 0) return ST_ZERO;
    frame_bytes = bytes_per_sample * 32'(chan_h);
    if (frame_bytes == 0 || (data_len_h % frame_bytes) != 0) return ST_PARTIAL;
    if (fmt_code_h == FMT_FLOAT && bits_h == BITS_FLOAT) return ST_OK;
    if (fmt_code_h == FMT_PCM && bits_h == BITS_PCM) return ST_OK;
    return ST_UNSUP;
  endfunction

  // Advance the shadow parser by one file byte and work out its output item.
  task automatic parse_file_byte(input logic [7:0] fbyte, input logic eof,
                                 output wav_item_t res);
    logic [3:0] st;
    res = '0;
    case (walk_phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
        if (walk_phase == PH_ID && pad_owed) begin
          // The pad byte after an odd-size chunk is dropped whatever it holds.
          pad_owed = 1'b0;
        end else begin
          tag_shift = {fbyte, tag_shift[31:8]};
          field_pos = field_pos + 5'd1;
          if (field_pos == 5'd4) begin
            field_pos = '0;
            case (walk_phase)
              PH_RIFF: begin
                if (tag_shift != TAG_RIFF) abort_parse(ST_BAD_RIFF);
                else walk_phase = PH_RSIZE;
              end
              PH_RSIZE: walk_phase = PH_WAVE;
              PH_WAVE: begin
                if (tag_shift != TAG_WAVE) abort_parse(ST_BAD_WAVE);
                else walk_phase = PH_ID;
              end
              PH_ID: begin
                if (tag_shift == TAG_FMT) chunk_type = KIND_FMT;
                else if (tag_shift == TAG_DATA) chunk_type = KIND_DATA;
                else chunk_type = KIND_OTHER;
                walk_phase = PH_SIZE;
              end
              default: take_size(tag_shift);
            endcase
          end
        end
      end
      PH_FMT: begin
        // Capture the fields of the first 16 body bytes.
        case (field_pos)
          5'd0:  fmt_code_h[7:0]  = fbyte;
          5'd1:  fmt_code_h[15:8] = fbyte;
          5'd2:  chan_h[7:0]      = fbyte;
          5'd3:  chan_h[15:8]     = fbyte;
          5'd4:  rate_h[7:0]      = fbyte;
          5'd5:  rate_h[15:8]     = fbyte;
          5'd6:  rate_h[23:16]    = fbyte;
          5'd7:  rate_h[31:24]    = fbyte;
          5'd14: bits_h[7:0]      = fbyte;
          5'd15: bits_h[15:8]     = fbyte;
          default: ;
        endcase
        remaining = remaining - 1;
        field_pos = field_pos + 5'd1;
        if (field_pos >= 5'd16) begin
          field_pos = '0;
          if (remaining == 0) finish_chunk();
          else walk_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        remaining = remaining - 1;
        if (remaining == 0) finish_chunk();
      end
      PH_DATA: begin
        res.pcm_valid   = 1'b1;
        res.pcm_byte    = fbyte;
        res.pcm_restart = (remaining == data_len_h);
        remaining = remaining - 1;
        if (remaining == 0) finish_chunk();
      end
      default: ;
    endcase

    // The last byte of a file carries the verdict and starts a new file.
    if (eof) begin
      st = file_verdict();
      res.status   = st;
      res.is_float = (st == ST_OK) && (fmt_code_h == FMT_FLOAT);
      res.channels = chan_h;
      res.rate     = rate_h;
      res.bits     = bits_h;
      res.length   = data_len_h;
      clear_parse();
    end
  endtask

  // Compare each output item with the oldest expectation, then predict new ones.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    wav_item_t got;
    wav_item_t want;
    if (!rst_ni) begin
      clear_parse();
      parsed_item_q.delete();
      pending_r <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pcm_byte    = m_axis_tdata[7:0];
        got.status      = m_axis_tdata[11:8];
        got.channels    = m_axis_tdata[27:12];
        got.rate        = m_axis_tdata[59:28];
        got.bits        = m_axis_tdata[75:60];
        got.length      = m_axis_tdata[107:76];
        got.pcm_valid   = m_axis_tuser[0];
        got.pcm_restart = m_axis_tuser[1];
        got.is_float    = m_axis_tuser[2];
        if (parsed_item_q.size() == 0) begin
          report_mismatch("item with no byte waiting", 32'(got.status), 32'(ST_NONE));
        end else begin
          want = parsed_item_q.pop_front();
          if (got.pcm_valid !== want.pcm_valid)
            report_mismatch("pcm_valid", 32'(got.pcm_valid), 32'(want.pcm_valid));
          if (got.pcm_byte !== want.pcm_byte)
            report_mismatch("pcm_byte", 32'(got.pcm_byte), 32'(want.pcm_byte));
          if (got.pcm_restart !== want.pcm_restart)
            report_mismatch("pcm_restart", 32'(got.pcm_restart), 32'(want.pcm_restart));
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.is_float !== want.is_float)
            report_mismatch("is_float", 32'(got.is_float), 32'(want.is_float));
          if (got.channels !== want.channels)
            report_mismatch("channel_count", 32'(got.channels), 32'(want.channels));
          if (got.rate !== want.rate)
            report_mismatch("rate_hz", got.rate, want.rate);
          if (got.bits !== want.bits)
            report_mismatch("sample_bits", 32'(got.bits), 32'(want.bits));
          if (got.length !== want.length)
            report_mismatch("payload_length", got.length, want.length);
          if (m_axis_tdata[111:108] !== 4'b0)
            report_mismatch("tdata fill bits", 32'(m_axis_tdata[111:108]), 32'd0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_file_byte(s_axis_tdata, s_axis_tlast, want);
        parsed_item_q.push_back(want);
      end
      pending_r <= parsed_item_q.size();
    end
  end

endmodule

/* dv/wav_riff_chunk_parser_core_tb.sv */
// Testbench top for the WAV RIFF chunk parser: builds WAV files, drives them and decides.
`timescale 1ns / 100ps

module wav_riff_chunk_parser_core_tb;
  import wrc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold = 0;
  bit          src_idle = 1'b1;
  bit          rx_idle = 1'b1;
  logic [7:0]  wav_bytes[$];

  wav_riff_chunk_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  wav_riff_chunk_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: after each taken item it may hold tready low for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) m_axis_tready <= 1'b1;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
    end else if (m_axis_tvalid) begin
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold <= gap;
      end
    end
  end

  // Count cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) wav_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic push_noise(input int nbytes);
    for (int i = 0; i < nbytes; i++) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // A chunk of unknown kind with a small body and its pad byte.
  task automatic add_skip_chunk();
    logic [31:0] size;
    size = $urandom_range(0, 6);
    push_le($urandom(), 4);
    push_le(size, 4);
    push_noise(int'(size) + int'(size[0]));
  endtask

  // A data chunk, mostly whole frames; a huge one never completes.
  task automatic add_data_chunk(input logic [31:0] frame, input bit huge);
    logic [31:0] size;
    int          body;
    if (huge) begin
      size = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'($urandom());
      body = $urandom_range(1, 20);
    end else begin
      if (frame >= 1 && frame <= 12 && $urandom_range(0, 3) != 0)
        size = frame * $urandom_range(0, 24 / frame);
      else
        size = $urandom_range(0, 24);
      body = int'(size) + int'(size[0]);
    end
    push_le(TAG_DATA, 4);
    push_le(size, 4);
    push_noise(body);
  endtask

  // Present one byte and wait until it is taken.
  task automatic send_byte(input logic [7:0] fbyte, input logic last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fbyte;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send the whole file buffer, tlast on the final byte.
  task automatic send_file();
    int n;
    src_idle = ($urandom_range(0, 2) != 0);
    rx_idle <= ($urandom_range(0, 2) != 0);
    n = wav_bytes.size();
    for (int i = 0; i < n; i++) send_byte(wav_bytes[i], i == n - 1);
    wav_bytes.delete();
  endtask

  initial begin : stimulus
    logic [15:0]  code;
    logic [15:0]  chans;
    logic [15:0]  bits;
    logic [31:0]  rate;
    logic [31:0]  frame;
    logic [127:0] fmt_body;
    int           fmt_size;
    int           sel;
    int           mode;
    int           pos;
    int           random_bytes;
    bit           data_first;
    bit           huge;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files: a lone byte, a bad RIFF tag, a bad WAVE tag, no chunks at all.
    push_le(32'h0, 1);
    send_file();
    push_le(TAG_RIFF ^ 32'h1000_0000, 4);
    send_file();
    push_le(TAG_RIFF, 4);
    push_le(32'hFFFF_FFFF, 4);
    push_le(TAG_WAVE ^ 32'h0000_0001, 4);
    send_file();
    push_le(TAG_RIFF, 4);
    push_le(32'h0, 4);
    push_le(TAG_WAVE, 4);
    send_file();

    // Random files: mostly well formed, some cut short, corrupted or pure noise.
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      mode = $urandom_range(0, 9);
      huge = (mode >= 6 && mode <= 7 && $urandom_range(0, 2) == 0);

      // Pick the fmt fields.
      chans = 16'($urandom_range(1, 2));
      rate  = ($urandom_range(0, 1) != 0) ? 32'd48000 : 32'($urandom_range(1, 200000));
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: begin
          code = FMT_PCM;
          bits = BITS_PCM;
        end
        4, 5: begin
          code = FMT_FLOAT;
          bits = BITS_FLOAT;
          if ($urandom_range(0, 3) == 0) chans = 16'($urandom_range(1, 8));
        end
        6: begin
          code = 16'($urandom_range(0, 65535));
          bits = 16'(8 * $urandom_range(1, 4));
        end
        7: begin
          // One field zero or too narrow.
          code = FMT_PCM;
          bits = BITS_PCM;
          case ($urandom_range(0, 2))
            0: chans = '0;
            1: rate = '0;
            default: bits = 16'($urandom_range(0, 7));
          endcase
        end
        8: begin
          code = FMT_PCM;
          bits = BITS_FLOAT;
          if ($urandom_range(0, 1) != 0) begin
            code = FMT_FLOAT;
            bits = BITS_PCM;
          end
        end
        default: begin
          code  = 16'($urandom());
          chans = 16'($urandom());
          rate  = $urandom();
          bits  = 16'($urandom());
          if ($urandom_range(0, 1) != 0) begin
            chans = '1;
            rate  = '1;
            bits  = '1;
          end
        end
      endcase
      frame = (32'(bits) / 8) * 32'(chans);

      // Build the file.
      push_le(TAG_RIFF, 4);
      push_le($urandom(), 4);
      push_le(TAG_WAVE, 4);
      if ($urandom_range(0, 2) == 0) add_skip_chunk();
      data_first = ($urandom_range(0, 3) == 0);
      if (data_first) begin
        add_data_chunk(frame, huge);
        if ($urandom_range(0, 1) != 0) add_data_chunk(frame, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) add_skip_chunk();
      if ($urandom_range(0, 7) == 0) fmt_size = $urandom_range(0, 15);
      else if ($urandom_range(0, 2) == 0) fmt_size = $urandom_range(17, 22);
      else fmt_size = 16;
      fmt_body = {bits, 16'($urandom()), 32'($urandom()), rate, chans, code};
      push_le(TAG_FMT, 4);
      push_le(32'(fmt_size), 4);
      for (int i = 0; i < fmt_size + (fmt_size % 2); i++)
        wav_bytes.push_back(i < 16 ? fmt_body[8*i +: 8] : 8'($urandom()));
      if (!data_first) add_data_chunk(frame, huge);
      push_noise($urandom_range(0, 3));

      // Break it as the mode says.
      if (mode == 6 || mode == 7) begin
        pos = $urandom_range(1, wav_bytes.size() - 1);
        while (wav_bytes.size() > pos) void'(wav_bytes.pop_back());
      end else if (mode == 8) begin
        pos = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 11)
                                          : $urandom_range(0, wav_bytes.size() - 1);
        wav_bytes[pos] = wav_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
      end else if (mode == 9) begin
        wav_bytes.delete();
        if ($urandom_range(0, 1) != 0) push_le(TAG_RIFF, 4);
        push_noise($urandom_range(1, 16));
      end

      random_bytes += wav_bytes.size();
      send_file();
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every expected item, then keep watching for strays before deciding.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/wrc_pkg.sv
rtl/wrc_mod.sv
rtl/wrc_dp.sv
rtl/wrc_ctrl.sv
rtl/wav_riff_chunk_parser_core.sv
dv/wav_riff_chunk_parser_checker.sv
dv/wav_riff_chunk_parser_core_tb.sv
